// ===== design/image_rotate_45_lookup_unit_assert.svh =====
// Assertion helpers shared by the rotate lookup design.
// All checks use clk and are held off while arst_n is low.
`ifndef IMAGE_ROTATE_45_LOOKUP_UNIT_ASSERT_SVH
`define IMAGE_ROTATE_45_LOOKUP_UNIT_ASSERT_SVH

// Same-cycle implication
`define IR45_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ir45 assertion failed");

// Implication after a fixed number of cycles
`define IR45_ASSERT_DLY(name, ante, n, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("ir45 assertion failed");

`endif

// ===== design/ir45_pkg.sv =====
package ir45_pkg;

	// field widths
	localparam int DIM_W   = 7;
	localparam int SIZE_W  = 8;
	localparam int TOTAL_W = 2 * DIM_W;
	localparam int PIX_W   = 24;
	localparam int ACC_W   = 28;

	// cos45 in Q0.16
	localparam logic [16:0] COS45_Q16 = 17'd46341;

	// configuration register indexes
	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;

	// request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// mapped source location handed from the mapper to the store
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic             invalid;
		logic [DIM_W-1:0] scol;
		logic [DIM_W-1:0] srow;
	} map_res_t;

	// clamp a dimension register to 1..max_dim
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input int unsigned max_dim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > max_dim) begin
			r = DIM_W'(max_dim);
		end
		return r;
	endfunction

	// rotated bounding box size: ceil((w + h) * cos45)
	function automatic logic [SIZE_W-1:0] rot_size(input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		logic [DIM_W:0] s;
		logic [25:0]    prod;
		s = {1'b0, w} + {1'b0, h};
		prod = 26'(s) * 26'(COS45_Q16) + 26'd65535;
		return prod[16 +: SIZE_W];
	endfunction

endpackage

// ===== design/ir45_map.sv =====
// Inverse mapping of a rotated-image position back into the source image.
// Three register stages: query in, scaled coordinates, source location.
module ir45_map (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          query,
	input  logic [ir45_pkg::DIM_W-1:0]    out_col,
	input  logic [ir45_pkg::DIM_W-1:0]    out_row,
	input  logic [ir45_pkg::DIM_W-1:0]    dim_w,
	input  logic [ir45_pkg::DIM_W-1:0]    dim_h,
	input  logic [ir45_pkg::SIZE_W-1:0]   size,
	output ir45_pkg::map_res_t            res_s3
);

	localparam logic signed [ir45_pkg::ACC_W-1:0] COS_S =
		ir45_pkg::ACC_W'(ir45_pkg::COS45_Q16);

	logic                        v_s1;
	logic [ir45_pkg::DIM_W-1:0]  col_s1;
	logic [ir45_pkg::DIM_W-1:0]  row_s1;

	logic                                v_s2;
	logic                                inv_s2;
	logic signed [ir45_pkg::ACC_W-1:0]   a_s2;
	logic signed [ir45_pkg::ACC_W-1:0]   b_s2;

	logic                                v_s3;
	logic                                hit_s3;
	logic                                inv_s3;
	logic [ir45_pkg::DIM_W-1:0]          scol_s3;
	logic [ir45_pkg::DIM_W-1:0]          srow_s3;

	logic                                inv_c;
	logic signed [8:0]                   p_c;
	logic signed [9:0]                   q_c;
	logic signed [ir45_pkg::ACC_W-1:0]   p_x;
	logic signed [ir45_pkg::ACC_W-1:0]   q_x;
	logic signed [ir45_pkg::ACC_W-1:0]   a_c;
	logic signed [ir45_pkg::ACC_W-1:0]   b_c;
	logic signed [ir45_pkg::ACC_W-1:0]   w_half;
	logic signed [ir45_pkg::ACC_W-1:0]   h_half;
	logic signed [ir45_pkg::ACC_W-1:0]   w_lim;
	logic signed [ir45_pkg::ACC_W-1:0]   h_lim;
	logic                                in_c;
	logic [ir45_pkg::DIM_W-1:0]          sbot_c;

	// stage 1: capture the query position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= query;
		end
	end

	always_ff @(posedge clk) begin
		if (query) begin
			col_s1 <= out_col;
			row_s1 <= out_row;
		end
	end

	// Halved Q.17 source coordinates, kept in Q.16:
	//   a = cos45 * (col - row - 1) + w/2,  b = cos45 * (W - 1 - row - col) + h/2
	assign inv_c = ({1'b0, col_s1} >= size) || ({1'b0, row_s1} >= size);
	assign p_c = $signed({2'b0, col_s1}) - $signed({2'b0, row_s1}) - 9'sd1;
	assign q_c = $signed({2'b0, size}) - $signed({3'b0, row_s1}) -
		$signed({3'b0, col_s1}) - 10'sd1;
	assign p_x = ir45_pkg::ACC_W'(p_c);
	assign q_x = ir45_pkg::ACC_W'(q_c);
	assign w_half = $signed({6'b0, dim_w, 15'b0});
	assign h_half = $signed({6'b0, dim_h, 15'b0});
	assign a_c = p_x * COS_S + w_half;
	assign b_c = q_x * COS_S + h_half;

	// stage 2: scaled coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			inv_s2 <= inv_c;
			a_s2   <= a_c;
			b_s2   <= b_c;
		end
	end

	// bounds check and truncation to a source pixel
	assign w_lim  = $signed({5'b0, dim_w, 16'b0});
	assign h_lim  = $signed({5'b0, dim_h, 16'b0});
	assign in_c   = !inv_s2 && (a_s2 >= 0) && (a_s2 < w_lim) &&
		(b_s2 >= 0) && (b_s2 < h_lim);
	assign sbot_c = b_s2[16 +: ir45_pkg::DIM_W];

	// stage 3: source location
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			hit_s3  <= in_c;
			inv_s3  <= inv_s2;
			scol_s3 <= a_s2[16 +: ir45_pkg::DIM_W];
			srow_s3 <= dim_h - ir45_pkg::DIM_W'(1) - sbot_c;
		end
	end

	assign res_s3 = {v_s3, hit_s3, inv_s3, scol_s3, srow_s3};

endmodule

// ===== design/image_rotate_45_lookup_unit.sv =====
// Rotate-by-45 lookup over a stored RGB image. Every request is taken with
// start while busy is low; busy is high only just after reset, so a request
// can be issued every cycle. A load request (req_type 0) writes the next pixel
// of the source image in stored row order and returns nothing. A query
// (req_type 1) returns one result, marked by done for exactly one cycle; the
// receiver cannot stall, so done must be sampled when it is high. A query
// passes the query register, the constant-coefficient multiply, the bounds
// check and the row*width address multiply, and then the registered read of
// the pixel memory. Loads travel the same stages, so a query sees exactly the
// loads issued before it. Source size is written on the configuration
// channel (index 0 width, 1 height), which also restarts loading; write it
// only when no query is in flight, and leave one cycle after a write before
// the next request. rot_width and rot_height give the rotated size.
`include "image_rotate_45_lookup_unit_assert.svh"

module image_rotate_45_lookup_unit #(
	parameter int unsigned MAX_DIM = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  pixel_red,
	input  logic [7:0]  pixel_green,
	input  logic [7:0]  pixel_blue,
	input  logic [6:0]  out_col,
	input  logic [6:0]  out_row,
	// result channel
	output logic        done,
	output logic [7:0]  res_red,
	output logic [7:0]  res_green,
	output logic [7:0]  res_blue,
	output logic        inside_res,
	output logic        query_invalid,
	output logic [6:0]  rot_width,
	output logic [6:0]  rot_height,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
	localparam int          ADDR_W = $clog2(DEPTH);
	localparam int          CMP_W  = (ADDR_W + 1 > ir45_pkg::TOTAL_W) ?
		ADDR_W + 1 : ir45_pkg::TOTAL_W;

	localparam logic [ir45_pkg::DIM_W-1:0]   RST_DIM   =
		ir45_pkg::eff_dim(7'd64, MAX_DIM);
	localparam logic [ir45_pkg::SIZE_W-1:0]  RST_SIZE  =
		ir45_pkg::rot_size(RST_DIM, RST_DIM);
	localparam logic [ir45_pkg::TOTAL_W-1:0] RST_TOTAL =
		ir45_pkg::TOTAL_W'(RST_DIM) * ir45_pkg::TOTAL_W'(RST_DIM);

	logic                             busy_q;
	logic [ir45_pkg::DIM_W-1:0]       dim_w_q;
	logic [ir45_pkg::DIM_W-1:0]       dim_h_q;
	logic [ir45_pkg::SIZE_W-1:0]      size_q;
	logic [ir45_pkg::TOTAL_W-1:0]     total_q;
	logic [ADDR_W-1:0]                load_pos_q;

	logic                             req_acc;
	logic                             cfg_acc;
	logic                             ld_acc;
	logic                             qry_acc;
	logic [ir45_pkg::DIM_W-1:0]       new_dim;
	logic [CMP_W-1:0]                 total_x;
	logic [ADDR_W-1:0]                pos_cur;
	logic [CMP_W-1:0]                 pos_inc;
	logic [ADDR_W-1:0]                pos_nxt;

	logic                             ld_v_s1, ld_v_s2, ld_v_s3;
	logic [ADDR_W-1:0]                ld_addr_s1, ld_addr_s2, ld_addr_s3;
	logic [ir45_pkg::PIX_W-1:0]       ld_pix_s1, ld_pix_s2, ld_pix_s3;

	ir45_pkg::map_res_t               map_s3;
	logic [CMP_W-1:0]                 rd_idx;
	logic [ir45_pkg::PIX_W-1:0]       pix_mem [DEPTH];
	logic [ir45_pkg::PIX_W-1:0]       rd_s4;
	logic                             v_s4;
	logic                             inside_s4;
	logic                             inv_s4;

	// handshakes
	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign req_acc   = start && !busy_q;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign ld_acc    = req_acc && (req_type == ir45_pkg::REQ_LOAD);
	assign qry_acc   = req_acc && (req_type == ir45_pkg::REQ_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// configuration: keep the clamped size and its derived values
	assign new_dim = ir45_pkg::eff_dim(cfg_data, MAX_DIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_w_q <= RST_DIM;
			dim_h_q <= RST_DIM;
			size_q  <= RST_SIZE;
			total_q <= RST_TOTAL;
		end else if (cfg_acc) begin
			case (cfg_index)
				ir45_pkg::REG_SRC_WIDTH: begin
					dim_w_q <= new_dim;
					size_q  <= ir45_pkg::rot_size(new_dim, dim_h_q);
					total_q <= ir45_pkg::TOTAL_W'(new_dim) *
						ir45_pkg::TOTAL_W'(dim_h_q);
				end
				ir45_pkg::REG_SRC_HEIGHT: begin
					dim_h_q <= new_dim;
					size_q  <= ir45_pkg::rot_size(dim_w_q, new_dim);
					total_q <= ir45_pkg::TOTAL_W'(dim_w_q) *
						ir45_pkg::TOTAL_W'(new_dim);
				end
				default: begin
				end
			endcase
		end
	end

	// load position, wraps at w*h
	assign total_x = CMP_W'(total_q);
	assign pos_cur = (CMP_W'(load_pos_q) >= total_x) ? '0 : load_pos_q;
	assign pos_inc = CMP_W'(pos_cur) + CMP_W'(1);
	assign pos_nxt = (pos_inc >= total_x) ? '0 : pos_inc[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
		end else if (cfg_acc && (cfg_index == ir45_pkg::REG_SRC_WIDTH ||
				cfg_index == ir45_pkg::REG_SRC_HEIGHT)) begin
			load_pos_q <= '0;
		end else if (ld_acc) begin
			load_pos_q <= pos_nxt;
		end
	end

	// load requests follow queries through the same stages to keep order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1 <= 1'b0;
			ld_v_s2 <= 1'b0;
			ld_v_s3 <= 1'b0;
		end else begin
			ld_v_s1 <= ld_acc;
			ld_v_s2 <= ld_v_s1;
			ld_v_s3 <= ld_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_acc) begin
			ld_addr_s1 <= pos_cur;
			ld_pix_s1  <= {pixel_red, pixel_green, pixel_blue};
		end
		if (ld_v_s1) begin
			ld_addr_s2 <= ld_addr_s1;
			ld_pix_s2  <= ld_pix_s1;
		end
		if (ld_v_s2) begin
			ld_addr_s3 <= ld_addr_s2;
			ld_pix_s3  <= ld_pix_s2;
		end
	end

	// coordinate mapping
	ir45_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.query   (qry_acc),
		.out_col (out_col),
		.out_row (out_row),
		.dim_w   (dim_w_q),
		.dim_h   (dim_h_q),
		.size    (size_q),
		.res_s3  (map_s3)
	);

	// pixel store: row-major address of the source pixel
	assign rd_idx = CMP_W'(map_s3.srow) * CMP_W'(dim_w_q) + CMP_W'(map_s3.scol);

	always_ff @(posedge clk) begin
		if (ld_v_s3) begin
			pix_mem[ld_addr_s3] <= ld_pix_s3;
		end
		if (map_s3.valid && map_s3.hit) begin
			rd_s4 <= pix_mem[rd_idx[ADDR_W-1:0]];
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= map_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (map_s3.valid) begin
			inside_s4 <= map_s3.hit;
			inv_s4    <= map_s3.invalid;
		end
	end

	assign done          = v_s4;
	assign inside_res    = inside_s4;
	assign query_invalid = inv_s4;
	assign res_red       = inside_s4 ? rd_s4[23:16] : 8'd0;
	assign res_green     = inside_s4 ? rd_s4[15:8]  : 8'd0;
	assign res_blue      = inside_s4 ? rd_s4[7:0]   : 8'd0;
	assign rot_width     = size_q[6:0];
	assign rot_height    = size_q[6:0];

	// checks
	`IR45_ASSERT_DLY(a_query_done, qry_acc, 4, done)
	`IR45_ASSERT_DLY(a_load_silent, ld_acc && !$past(qry_acc, 3), 4, !done)
	`IR45_ASSERT_IMP(a_inv_not_inside, done && query_invalid, !inside_res)
	`IR45_ASSERT_IMP(a_pos_in_image, 1'b1, CMP_W'(load_pos_q) < total_x)

endmodule
